// ===== design/ankf_pkg.sv =====
package ankf_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned ModeW = 2;
	localparam int unsigned OutW  = 8;

	// codec_mode register codes; anything else means no scan
	localparam logic [ModeW-1:0] MODE_H264  = 2'd0;
	localparam logic [ModeW-1:0] MODE_H265  = 2'd1;
	localparam logic [ModeW-1:0] MODE_OTHER = 2'd2;

	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic             last_byte;
		logic             clean_point;
	} in_item_t;

	typedef struct packed {
		logic needs_seq_header;
		logic key_frame;
		logic has_idr;
		logic has_param_sets;
	} result_t;

	function automatic logic is_h26x(input logic [ModeW-1:0] mode);
		return (mode == MODE_H264) || (mode == MODE_H265);
	endfunction

	function automatic logic is_param_set(input logic [ModeW-1:0] mode,
			input logic [ByteW-1:0] hdr);
		logic [5:0] t265;
		logic [4:0] t264;
		t265 = hdr[6:1];
		t264 = hdr[4:0];
		if (mode == MODE_H265) begin
			return t265 inside {6'd32, 6'd33, 6'd34};
		end else if (mode == MODE_H264) begin
			return t264 inside {5'd7, 5'd8};
		end
		return 1'b0;
	endfunction

	function automatic logic is_idr(input logic [ModeW-1:0] mode,
			input logic [ByteW-1:0] hdr);
		logic [5:0] t265;
		logic [4:0] t264;
		t265 = hdr[6:1];
		t264 = hdr[4:0];
		if (mode == MODE_H265) begin
			return t265 inside {[6'd16:6'd21]};
		end else if (mode == MODE_H264) begin
			return t264 == 5'd5;
		end
		return 1'b0;
	endfunction

endpackage

// ===== design/ankf_scan.sv =====
module ankf_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  ankf_pkg::in_item_t          item,
	input  logic [ankf_pkg::ModeW-1:0]  codec_mode,
	output ankf_pkg::result_t           result
);

	logic [1:0] zero_run_q;
	logic       header_expected_q;
	logic       ps_seen_q;
	logic       idr_seen_q;

	logic       ps_next;
	logic       idr_next;
	logic [1:0] zero_run_next;
	logic       header_next;
	logic       h26x;

	always_comb begin
		ps_next  = ps_seen_q;
		idr_next = idr_seen_q;
		if (header_expected_q) begin
			ps_next  = ps_seen_q  | ankf_pkg::is_param_set(codec_mode, item.data_byte);
			idr_next = idr_seen_q | ankf_pkg::is_idr(codec_mode, item.data_byte);
		end

		header_next = 1'b0;
		if (item.data_byte == '0) begin
			zero_run_next = (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
		end else begin
			// 01 after two or more zeros closes a start code
			header_next   = (item.data_byte == 8'd1) && (zero_run_q == 2'd2);
			zero_run_next = 2'd0;
		end

		h26x = ankf_pkg::is_h26x(codec_mode);
		result.has_param_sets   = h26x & ps_next;
		result.has_idr          = h26x & idr_next;
		result.key_frame        = item.clean_point | (h26x & idr_next);
		result.needs_seq_header = h26x & result.key_frame & ~ps_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q        <= 2'd0;
			header_expected_q <= 1'b0;
			ps_seen_q         <= 1'b0;
			idr_seen_q        <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				zero_run_q        <= 2'd0;
				header_expected_q <= 1'b0;
				ps_seen_q         <= 1'b0;
				idr_seen_q        <= 1'b0;
			end else begin
				zero_run_q        <= zero_run_next;
				header_expected_q <= header_next;
				ps_seen_q         <= ps_next;
				idr_seen_q        <= idr_next;
			end
		end
	end

endmodule

// ===== design/annexb_nal_keyframe_scanner_core.sv =====
// Annex B start-code scanner and key-frame classifier.
// Input stream: one packet byte per transfer on s_axis, tlast on the final
// byte of the packet, tuser carries the encoder's clean point flag (only
// looked at with the final byte).
// Output stream: one transfer per packet, issued for its final byte, with
// has_param_sets, has_idr, key_frame and needs_seq_header in m_axis_tdata.
// Non-final bytes give no output transfer.
// Config channel: cfg_data is codec_mode (0 H.264, 1 H.265, else no scan);
// always ready, to be written only while no packet is in flight.
// Pipeline: a byte is held in an input register, the classify logic then
// loads the output register, from which the result for the packet is
// offered. Throughput is one byte per cycle while the output is not
// stalled, set by the single register stage ahead of the per-packet state
// update.
// Reset clears the packet state, the pipeline valids and codec_mode
// (H.264). When m_axis stalls, the result holds in the output register;
// non-final bytes keep flowing until a second final byte waits behind it,
// then s_axis_tready drops until the output is taken.
module annexb_nal_keyframe_scanner_core (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ankf_pkg::ByteW-1:0]        s_axis_tdata,   // [7:0] data_byte
	input  logic                              s_axis_tlast,   // last_byte
	input  logic                              s_axis_tuser,   // clean_point

	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] has_param_sets, [1] has_idr, [2] key_frame, [3] needs_seq_header,
	// [7:4] zero
	output logic [ankf_pkg::OutW-1:0]         m_axis_tdata,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ankf_pkg::ModeW-1:0]        cfg_data
);

	logic                        valid_s1;
	ankf_pkg::in_item_t          item_s1;
	logic [ankf_pkg::ModeW-1:0]  codec_mode_q;
	ankf_pkg::result_t           result;
	logic                        out_free;
	logic                        advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= ankf_pkg::MODE_H264;
		end else if (cfg_valid) begin
			codec_mode_q <= cfg_data;
		end
	end

	assign out_free      = ~m_axis_tvalid | m_axis_tready;
	// a non-final byte needs no output slot
	assign advance       = valid_s1 & (~item_s1.last_byte | out_free);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.data_byte   <= s_axis_tdata;
			item_s1.last_byte   <= s_axis_tlast;
			item_s1.clean_point <= s_axis_tuser;
		end
	end

	ankf_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.codec_mode (codec_mode_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= advance & item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && item_s1.last_byte) begin
			m_axis_tdata <= {{(ankf_pkg::OutW - $bits(ankf_pkg::result_t)){1'b0}}, result};
		end
	end

endmodule

// ===== design/ankf_checker.sv =====
module ankf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ankf_pkg::OutW-1:0]         m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// input only blocks behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	a_idr_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
		else $error("idr without key_frame");

	a_need_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2] && !m_axis_tdata[0])
		else $error("needs_seq_header inconsistent");

endmodule

bind annexb_nal_keyframe_scanner_core ankf_checker u_ankf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/nal_tb_pkg.sv =====
package nal_tb_pkg;

	// NAL unit types that the scanner reacts to
	localparam logic [4:0] H264_IDR     = 5'd5;
	localparam logic [4:0] H264_SPS     = 5'd7;
	localparam logic [4:0] H264_PPS     = 5'd8;
	localparam logic [5:0] H265_IRAP_LO = 6'd16;
	localparam logic [5:0] H265_IRAP_HI = 6'd21;
	localparam logic [5:0] H265_VPS     = 6'd32;
	localparam logic [5:0] H265_PPS     = 6'd34;

	// codec_mode code left unused by the block, behaves as no scan
	localparam logic [1:0] MODE_UNUSED = 2'd3;

endpackage

// ===== tb/keyframe_checker.sv =====
module keyframe_checker import ankf_pkg::*, nal_tb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [ByteW-1:0]  s_axis_tdata,
	input  logic              s_axis_tlast,
	input  logic              s_axis_tuser,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [OutW-1:0]   m_axis_tdata,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ModeW-1:0]  cfg_data,
	output int unsigned       failures,
	output int unsigned       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ModeW-1:0] codec;
	logic [1:0]       zeros;
	logic             hdr_next;
	logic             ps_flag;
	logic             idr_flag;
	result_t          packet_flags_q[$];

	initial failures = 0;

	task automatic classify_hdr(input logic [ByteW-1:0] hdr);
		logic [5:0] t265;
		logic [4:0] t264;
		t265 = hdr[6:1];
		t264 = hdr[4:0];
		case (codec)
			MODE_H265: begin
				if (t265 >= H265_VPS && t265 <= H265_PPS)
					ps_flag = 1'b1;
				if (t265 >= H265_IRAP_LO && t265 <= H265_IRAP_HI)
					idr_flag = 1'b1;
			end
			MODE_H264: begin
				if (t264 == H264_SPS || t264 == H264_PPS)
					ps_flag = 1'b1;
				if (t264 == H264_IDR)
					idr_flag = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic scan_byte(input logic [ByteW-1:0] b, input logic fin, input logic clean);
		result_t want;
		logic    h26x;
		if (hdr_next) begin
			classify_hdr(b);
			hdr_next = 1'b0;
		end
		// the header byte may also open the next start code
		if (b == 8'h00) begin
			if (zeros < 2'd2)
				zeros = zeros + 2'd1;
		end else begin
			if (b == 8'h01 && zeros == 2'd2)
				hdr_next = 1'b1;
			zeros = 2'd0;
		end
		if (fin) begin
			h26x = (codec == MODE_H264) || (codec == MODE_H265);
			want.has_param_sets   = h26x & ps_flag;
			want.has_idr          = h26x & idr_flag;
			want.key_frame        = clean | want.has_idr;
			want.needs_seq_header = h26x & want.key_frame & ~want.has_param_sets;
			packet_flags_q.push_back(want);
			zeros    = 2'd0;
			hdr_next = 1'b0;
			ps_flag  = 1'b0;
			idr_flag = 1'b0;
		end
	endtask

	task automatic check_flag(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			codec    = MODE_H264;
			zeros    = 2'd0;
			hdr_next = 1'b0;
			ps_flag  = 1'b0;
			idr_flag = 1'b0;
			packet_flags_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				codec = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				scan_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[3:0]);
				if (packet_flags_q.size() == 0) begin
					$error("output transfer with no packet result pending: %h", m_axis_tdata);
					failures++;
				end else begin
					want = packet_flags_q.pop_front();
					check_flag("has_param_sets", want.has_param_sets, got.has_param_sets);
					check_flag("has_idr", want.has_idr, got.has_idr);
					check_flag("key_frame", want.key_frame, got.key_frame);
					check_flag("needs_seq_header", want.needs_seq_header,
						got.needs_seq_header);
				end
			end
		end
		pending = packet_flags_q.size();
	end

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ankf_pkg::*;
	import nal_tb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [ByteW-1:0]  s_axis_tdata;
	logic              s_axis_tlast;
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OutW-1:0]   m_axis_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ModeW-1:0]  cfg_data;

	int unsigned       failures;
	int unsigned       pending;
	logic              quiet;
	logic              long_hold;

	annexb_nal_keyframe_scanner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	keyframe_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	// result side: random stall bursts, plus one long hold-off
	initial begin : receiver
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [ByteW-1:0] b, input logic fin, input logic clean);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		s_axis_tuser  <= clean;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [ByteW-1:0] bytes[$], input logic clean);
		foreach (bytes[i])
			push_byte(bytes[i], i == bytes.size() - 1,
				(i == bytes.size() - 1) ? clean : 1'($urandom));
	endtask

	task automatic write_mode(input logic [ModeW-1:0] mode);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data  <= mode;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ByteW-1:0] pick_header(input logic [ModeW-1:0] mode);
		logic [ByteW-1:0] h;
		h = 8'($urandom);
		case (mode)
			MODE_H264: begin
				case ($urandom_range(0, 4))
					0: h[4:0] = H264_IDR;
					1: h[4:0] = H264_SPS;
					2: h[4:0] = H264_PPS;
					default: ;
				endcase
			end
			MODE_H265: begin
				case ($urandom_range(0, 3))
					0: h[6:1] = 6'($urandom_range(H265_IRAP_LO, H265_IRAP_HI));
					1: h[6:1] = 6'($urandom_range(H265_VPS, H265_PPS));
					default: ;
				endcase
			end
			default: ;
		endcase
		return h;
	endfunction

	// returns the number of bytes sent
	task automatic random_packet(input logic [ModeW-1:0] mode, output int n);
		logic [ByteW-1:0] bytes[$];
		int               units;
		if ($urandom_range(0, 4) == 0) begin
			// noise: zero-heavy random bytes, start codes appear by chance
			repeat ($urandom_range(1, 10)) begin
				case ($urandom_range(0, 5))
					0, 1, 2: bytes.push_back(8'h00);
					3:       bytes.push_back(8'h01);
					default: bytes.push_back(8'($urandom));
				endcase
			end
		end else begin
			units = $urandom_range(0, 3);
			for (int u = 0; u < units; u++) begin
				if ($urandom_range(0, 2) == 0)
					bytes.push_back(8'h00);
				bytes.push_back(8'h00);
				bytes.push_back(8'h00);
				bytes.push_back(8'h01);
				// sometimes the packet stops right after the start code
				if (u == units - 1 && $urandom_range(0, 7) == 0)
					break;
				bytes.push_back(pick_header(mode));
				repeat ($urandom_range(0, 4))
					bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			end
			if (bytes.size() == 0)
				bytes.push_back(8'($urandom));
		end
		send_packet(bytes, 1'($urandom));
		n = bytes.size();
	endtask

	initial begin
		logic [ModeW-1:0] phase_modes[6];
		int               sent;
		int               n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		quiet         = 1'b0;
		long_hold     = 1'b0;
		phase_modes   = '{MODE_H265, MODE_H264, MODE_OTHER, MODE_UNUSED, MODE_H265, MODE_H264};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed packets, H.264 rules after reset
		send_packet('{8'h00, 8'h00, 8'h01, 8'h65}, 1'b0);         // IDR without SPS/PPS
		send_packet('{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF}, 1'b0); // long zero run, SPS
		send_packet('{8'h00, 8'h00, 8'h01}, 1'b1);               // start code ends packet
		send_packet('{8'hFF}, 1'b1);
		send_packet('{8'h00}, 1'b0);
		// header byte 00 starts the next start code, then PPS
		send_packet('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h68}, 1'b0);

		foreach (phase_modes[p]) begin
			write_mode(phase_modes[p]);
			if (p == 1) begin
				fork
					begin
						@(posedge clk);
						long_hold = 1'b1;
						repeat (400) @(posedge clk);
						long_hold = 1'b0;
					end
				join_none
			end
			if (p == 5) begin
				@(posedge clk);
				quiet = 1'b1;
				@(negedge clk);
			end
			sent = 0;
			while (sent < 130) begin
				random_packet(phase_modes[p], n);
				sent += n;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
